// ===== sv/rms_norm_row_engine_macros.svh =====
// Assertion helpers shared by the checker
`ifndef RMS_NORM_ROW_ENGINE_MACROS_SVH
`define RMS_NORM_ROW_ENGINE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RNR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RNR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/rnr_pkg.sv =====
`default_nettype none
package rnr_pkg;
    localparam int MAX_ROW_DEF   = 64;
    localparam int DATA_BITS_DEF = 16;
    localparam int LEN_W         = 7;
    localparam int EPS_W         = 16;
    localparam int SUM_W         = 38;
    localparam int INV_W         = 24;
    localparam int IDX_W         = 6;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    localparam logic REG_ROW_LENGTH = 1'b0;
    localparam logic REG_EPSILON    = 1'b1;

    localparam logic FUNC_GAMMA  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_RDIV  = 8'b0000_0100,
        ST_SQRT  = 8'b0000_1000,
        ST_RD    = 8'b0001_0000,
        ST_MUL1  = 8'b0010_0000,
        ST_MUL2  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;
endpackage
`default_nettype wire

// ===== sv/rms_norm_row_engine.sv =====
// Channel  | Dir | Payload
// s_axis   | in  | tdata = value; tuser = {index, func} (func at bit 0)
// m_axis   | out | tdata = y; tlast = last
// cfg      | in  | cfg_wr_en / cfg_index / cfg_data, register 0 row_length, 1 epsilon
// After a gamma load or a non-final sample is accepted, s_axis_tready drops for one idle cycle.
// The final sample of a row starts a shared serial unit: the division of the sum
// by the length, then the inverse square root (2^48 / S, then a digit-by-digit square root).
// Each result then passes through RD, MUL1 (16x16) and MUL2 (32x24 with inv), then OUT, plus stalls.
// Reset is synchronous, active low; the buffers themselves are not cleared.
// m_axis_tvalid holds until the transfer; no new item is taken during a row's output.
`default_nettype none
module rms_norm_row_engine #(
    parameter int MAX_ROW   = rnr_pkg::MAX_ROW_DEF,
    parameter int DATA_BITS = rnr_pkg::DATA_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [DATA_BITS-1:0]      s_axis_tdata,  // value
    input  wire logic [rnr_pkg::IDX_W:0]   s_axis_tuser,  // func, index[5:0]
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [DATA_BITS-1:0]           m_axis_tdata,  // y
    output logic                           m_axis_tlast,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_index,
    input  wire logic [rnr_pkg::EPS_W-1:0] cfg_data
);
    localparam int AW  = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
    localparam int CW  = $clog2(MAX_ROW + 1);
    localparam int SW  = rnr_pkg::SUM_W;
    localparam int IW  = rnr_pkg::INV_W;
    localparam int PW  = 2 * DATA_BITS;
    localparam int QW  = 49;               // quotient 2^48/S

    rnr_pkg::state_t state_reg, state_next;
    logic [rnr_pkg::LEN_W-1:0] len_cfg_reg;
    logic [rnr_pkg::EPS_W-1:0] eps_reg;
    logic [CW-1:0] fill_reg;
    logic [SW-1:0] sum_reg;
    logic [IW-1:0] inv_reg;
    logic [6:0]    cnt_reg;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] quo_reg;
    logic [QW-1:0] num_reg;                // shift-in dividend / radicand
    logic [QW:0]   drem_reg;
    logic [SW:0]   s_reg;
    logic [CW-1:0] k_reg;
    logic [PW-1:0] prod_reg;
    logic          neg_reg;
    logic [DATA_BITS-1:0] y_reg;
    logic          last_reg;
    logic          busy_reg;               // one idle cycle after each accept

    logic [DATA_BITS-1:0] x_rd, g_rd;

    wire logic func = s_axis_tuser[0];
    wire logic [rnr_pkg::IDX_W-1:0] idx = s_axis_tuser[rnr_pkg::IDX_W:1];
    wire logic acc = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == rnr_pkg::ST_IDLE) && !busy_reg;

    // effective length
    logic [CW-1:0] len_eff;
    always_comb begin
        if (len_cfg_reg == '0) begin
            len_eff = CW'(1);
        end else if ({25'd0, len_cfg_reg} > MAX_ROW) begin
            len_eff = CW'(MAX_ROW);
        end else begin
            len_eff = CW'(len_cfg_reg);
        end
    end

    logic [CW-1:0] wr_pos;
    assign wr_pos = (fill_reg >= CW'(MAX_ROW)) ? CW'(MAX_ROW - 1) : fill_reg;

    logic [DATA_BITS-1:0] mag_in;
    assign mag_in = s_axis_tdata[DATA_BITS-1] ? DATA_BITS'(-s_axis_tdata) : s_axis_tdata;
    logic [PW-1:0] sq;
    assign sq = mag_in * mag_in;
    logic [SW:0] sum_add;
    assign sum_add = {1'b0, sum_reg} + (SW+1)'(sq);

    wire logic gw = acc && func == rnr_pkg::FUNC_GAMMA && {26'd0, idx} < MAX_ROW;
    wire logic sw = acc && func == rnr_pkg::FUNC_SAMPLE;

    rnr_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_ROW)) u_row (
        .aclk(aclk), .wr_en(sw), .wr_addr(wr_pos[AW-1:0]), .wr_data(s_axis_tdata),
        .rd_addr(k_reg[AW-1:0]), .rd_data(x_rd)
    );
    rnr_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_ROW)) u_gamma (
        .aclk(aclk), .wr_en(gw), .wr_addr(AW'(idx)), .wr_data(s_axis_tdata),
        .rd_addr(k_reg[AW-1:0]), .rd_data(g_rd)
    );

    // restoring division step
    logic [SW:0] dtry;
    assign dtry = {rem_reg, quo_reg[SW-1]} - (SW+1)'(fill_reg);
    // 2^48 / S step
    logic [QW:0] qtry;
    assign qtry = {drem_reg[QW-1:0], num_reg[QW-1]} - (QW+1)'(s_reg);
    // digit-by-digit sqrt of num_reg[47:0], bit pairs from the top; result in inv
    logic [QW+2:0] rtry;
    assign rtry = {drem_reg, num_reg[QW-2 -: 2]} - {(QW-IW+1)'(0), inv_reg, 2'b01};

    // multipliers: step1 mx*mg, step2 product * inv by halves
    logic [DATA_BITS-1:0] mx, mg;
    assign mx = x_rd[DATA_BITS-1] ? DATA_BITS'(-x_rd) : x_rd;
    assign mg = g_rd[DATA_BITS-1] ? DATA_BITS'(-g_rd) : g_rd;
    logic [PW+IW-1:0] rr;
    logic [PW+IW-1:0] rr_reg;
    logic [PW-1:0] hi, lo;
    assign hi = prod_reg >> IW;
    assign lo = prod_reg & PW'((1 << IW) - 1);
    assign rr = (PW+IW)'(hi) * (PW+IW)'(inv_reg)
              + (((PW+IW)'(lo) * (PW+IW)'(inv_reg) + (PW+IW)'(1 << (IW-1))) >> IW);

    logic [PW+IW-1:0] lim;
    assign lim = (PW+IW)'(1) << (DATA_BITS - 1);
    logic [DATA_BITS-1:0] ysat;
    always_comb begin
        if (neg_reg) begin
            ysat = (rr_reg > lim) ? DATA_BITS'(-lim) : DATA_BITS'(-rr_reg);
        end else begin
            ysat = (rr_reg > lim - 1) ? DATA_BITS'(lim - 1) : DATA_BITS'(rr_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rnr_pkg::ST_IDLE: if (sw && wr_pos + 1'b1 >= len_eff) state_next = rnr_pkg::ST_DIV;
            rnr_pkg::ST_DIV:  if (cnt_reg == 7'(SW - 1)) state_next = rnr_pkg::ST_RDIV;
            rnr_pkg::ST_RDIV: if (cnt_reg == 7'(QW - 1)) state_next = rnr_pkg::ST_SQRT;
            rnr_pkg::ST_SQRT: if (cnt_reg == 7'(IW - 1)) state_next = rnr_pkg::ST_RD;
            rnr_pkg::ST_RD:   state_next = rnr_pkg::ST_MUL1;
            rnr_pkg::ST_MUL1: state_next = rnr_pkg::ST_MUL2;
            rnr_pkg::ST_MUL2: state_next = rnr_pkg::ST_OUT;
            rnr_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    state_next = last_reg ? rnr_pkg::ST_IDLE : rnr_pkg::ST_RD;
                end
            end
            default: state_next = rnr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rnr_pkg::ST_IDLE;
            len_cfg_reg <= rnr_pkg::LEN_RESET;
            eps_reg     <= rnr_pkg::EPS_RESET;
            fill_reg    <= '0;
            sum_reg     <= '0;
            inv_reg     <= '0;
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            k_reg       <= '0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= acc;
            if (cfg_wr_en) begin
                if (cfg_index == rnr_pkg::REG_ROW_LENGTH) begin
                    len_cfg_reg <= cfg_data[rnr_pkg::LEN_W-1:0];
                end else begin
                    eps_reg <= cfg_data;
                end
            end
            case (state_reg)
                rnr_pkg::ST_IDLE: begin
                    cnt_reg <= '0;
                    if (sw) begin
                        fill_reg <= wr_pos + 1'b1;
                        sum_reg  <= sum_add[SW] ? '1 : sum_add[SW-1:0];
                        if (sum_add[SW] || sum_add[SW-1:0] == '1) sum_reg <= '1;
                        quo_reg  <= sum_add[SW] ? '1 : sum_add[SW-1:0];
                        rem_reg  <= '0;
                    end
                end
                rnr_pkg::ST_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    quo_reg <= {quo_reg[SW-2:0], !dtry[SW]};
                    rem_reg <= dtry[SW] ? {rem_reg[SW-2:0], quo_reg[SW-1]} : dtry[SW-1:0];
                    if (cnt_reg == 7'(SW - 1)) begin
                        cnt_reg  <= '0;
                        s_reg    <= (SW+1)'({quo_reg[SW-2:0], !dtry[SW]}) + (SW+1)'(eps_reg);
                        num_reg  <= QW'(1) << 48;
                        drem_reg <= '0;
                    end
                end
                rnr_pkg::ST_RDIV: begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    num_reg  <= {num_reg[QW-2:0], !qtry[QW]};
                    drem_reg <= qtry[QW] ? {drem_reg[QW-1:0], num_reg[QW-1]} : qtry;
                    if (cnt_reg == 7'(QW - 1)) begin
                        cnt_reg  <= '0;
                        num_reg  <= {num_reg[QW-2:0], !qtry[QW]};
                        drem_reg <= '0;
                        inv_reg  <= '0;
                    end
                end
                rnr_pkg::ST_SQRT: begin
                    // top bit stays put and only flags a quotient of 2^48 for saturation
                    cnt_reg  <= cnt_reg + 1'b1;
                    num_reg  <= {num_reg[QW-1], num_reg[QW-4:0], 2'b00};
                    if (!rtry[QW+2]) begin
                        drem_reg <= rtry[QW:0];
                        inv_reg  <= {inv_reg[IW-2:0], 1'b1};
                    end else begin
                        drem_reg <= {drem_reg[QW-2:0], num_reg[QW-2 -: 2]};
                        inv_reg  <= {inv_reg[IW-2:0], 1'b0};
                    end
                    if (cnt_reg == 7'(IW - 1)) begin
                        k_reg <= '0;
                        if (s_reg == '0 || num_reg[QW-1]) inv_reg <= '1;
                    end
                end
                rnr_pkg::ST_MUL1: begin
                    prod_reg <= mx * mg;
                    neg_reg  <= x_rd[DATA_BITS-1] ^ g_rd[DATA_BITS-1];
                end
                rnr_pkg::ST_MUL2: begin
                    rr_reg   <= rr;
                    last_reg <= (k_reg + 1'b1 == fill_reg);
                end
                rnr_pkg::ST_OUT: begin
                    if (m_axis_tready) begin
                        k_reg <= k_reg + 1'b1;
                        if (last_reg) begin
                            fill_reg <= '0;
                            sum_reg  <= '0;
                            k_reg    <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign y_reg         = ysat;
    assign m_axis_tvalid = state_reg == rnr_pkg::ST_OUT;
    assign m_axis_tdata  = y_reg;
    assign m_axis_tlast  = last_reg;
endmodule
`default_nettype wire

// ===== sv/rnr_ram.sv =====
`default_nettype none
module rnr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== sv/rnr_checker.sv =====
`default_nettype none
`include "rms_norm_row_engine_macros.svh"
module rnr_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tlast
);
    `RNR_ASSERT_IMP(a_no_in_during_out, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    `RNR_ASSERT_NXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `RNR_ASSERT_NXT(a_gap_after_in, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RNR_ASSERT_NXT(a_no_out_after_last, aclk, aresetn,
        m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
endmodule

bind rms_norm_row_engine rnr_checker u_rnr_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

// ===== sim/tb_rms_norm_row_engine.sv =====
`default_nettype none
module tb_rms_norm_row_engine;
    localparam int ROW_MAX   = rnr_pkg::MAX_ROW_DEF;
    localparam int DW        = rnr_pkg::DATA_BITS_DEF;
    localparam int STALL_CAP = 20000;

    typedef struct packed {
        logic                      func;
        logic [rnr_pkg::IDX_W-1:0] idx;
        logic [DW-1:0]             value;
    } norm_item_t;

    typedef struct packed {
        logic [DW-1:0] y;
        logic          last;
    } norm_out_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    wire                      s_axis_tready;
    logic [DW-1:0]            s_axis_tdata = '0;   // value
    logic [rnr_pkg::IDX_W:0]  s_axis_tuser = '0;   // func, index[5:0]
    wire                      m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    wire  [DW-1:0]            m_axis_tdata;        // y
    wire                      m_axis_tlast;
    logic                     cfg_wr_en = 1'b0;
    logic                     cfg_index = 1'b0;
    logic [rnr_pkg::EPS_W-1:0] cfg_data = '0;

    rms_norm_row_engine dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    norm_item_t   pending_items[$];
    norm_out_t    expected_norm[$];
    int           errors = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           quiet_cycles = 0;

    // predictor state
    logic [DW-1:0] gamma_mem[ROW_MAX];
    logic [DW-1:0] row_mem[ROW_MAX];
    logic [63:0]   sq_total = 0;
    int            row_fill = 0;
    logic [63:0]   inv_rms = 0;
    logic [rnr_pkg::LEN_W-1:0] cur_len = rnr_pkg::LEN_RESET;
    logic [rnr_pkg::EPS_W-1:0] cur_eps = rnr_pkg::EPS_RESET;

    initial begin
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [63:0] abs_word(input logic [DW-1:0] v);
        return v[DW-1] ? 64'((~v) + 1'b1) & 64'hFFFF : 64'(v);
    endfunction

    task automatic predict_norm(input norm_item_t it);
        int          len;
        logic [63:0] sq, s, t, q, c, p, hi, lo, r;
        norm_out_t   o;
        if (it.func == rnr_pkg::FUNC_GAMMA) begin
            gamma_mem[it.idx] = it.value;
            return;
        end
        len = cur_len;
        if (len == 0) len = 1;
        if (len > ROW_MAX) len = ROW_MAX;
        if (row_fill >= ROW_MAX) row_fill = ROW_MAX - 1;
        row_mem[row_fill] = it.value;
        row_fill++;
        sq = abs_word(it.value) * abs_word(it.value);
        if (sq > (64'd1 << rnr_pkg::SUM_W) - 1 - sq_total)
            sq_total = (64'd1 << rnr_pkg::SUM_W) - 1;
        else sq_total += sq;
        if (row_fill < len) return;
        s = sq_total / row_fill + cur_eps;
        if (s == 0) begin
            inv_rms = (64'd1 << rnr_pkg::INV_W) - 1;
        end else begin
            t = (64'd1 << 48) / s;
            q = 0;
            for (int b = 31; b >= 0; b--) begin
                c = q | (64'd1 << b);
                if (c * c <= t) q = c;
            end
            inv_rms = q > (64'd1 << rnr_pkg::INV_W) - 1 ? (64'd1 << rnr_pkg::INV_W) - 1 : q;
        end
        for (int k = 0; k < row_fill; k++) begin
            p  = abs_word(row_mem[k]) * abs_word(gamma_mem[k]);
            hi = p >> 24;
            lo = p & ((64'd1 << 24) - 1);
            r  = hi * inv_rms + ((lo * inv_rms + (64'd1 << 23)) >> 24);
            if (row_mem[k][DW-1] != gamma_mem[k][DW-1]) begin
                if (r > 64'd32768) r = 64'd32768;
                o.y = DW'(~r + 1);
            end else begin
                if (r > 64'd32767) r = 64'd32767;
                o.y = DW'(r);
            end
            o.last = (k + 1 == row_fill);
            expected_norm.push_back(o);
        end
        row_fill = 0;
        sq_total = 0;
    endtask

    // driver: hold the transfer until taken, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_norm(pending_items.pop_front());
            end
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_items[0].value;
                s_axis_tuser  <= {pending_items[0].idx, pending_items[0].func};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_norm.size() == 0) begin
                    report_mismatch("unexpected result y", $signed(m_axis_tdata), 0);
                end else begin
                    if (m_axis_tdata !== expected_norm[0].y)
                        report_mismatch("y", $signed(m_axis_tdata),
                                        $signed(expected_norm[0].y));
                    if (m_axis_tlast !== expected_norm[0].last)
                        report_mismatch("last", m_axis_tlast, expected_norm[0].last);
                    void'(expected_norm.pop_front());
                end
            end
        end
    end

    // watchdog: cycles with work outstanding but no transfer on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (pending_items.size() == 0 && expected_norm.size() == 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_CAP) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_item(input logic f, input int idx, input int v);
        norm_item_t it;
        it.func  = f;
        it.idx   = rnr_pkg::IDX_W'(idx);
        it.value = DW'(v);
        pending_items.push_back(it);
    endtask

    // wait for the block to go quiet, then allow for a row end in flight
    task automatic drain;
        while (pending_items.size() > 0 || expected_norm.size() > 0 || s_axis_tvalid)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(input logic which, input int v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_data  <= rnr_pkg::EPS_W'(v);
        if (which == rnr_pkg::REG_ROW_LENGTH) cur_len = rnr_pkg::LEN_W'(v);
        else cur_eps = rnr_pkg::EPS_W'(v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int rand_word();
        case ($urandom_range(3))
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return $urandom_range(0, 1023) - 512;
        endcase
    endfunction

    initial begin
        int idle_modes[5][2] = '{'{0, 0}, '{68, 0}, '{0, 68}, '{12, 12}, '{0, 0}};
        int n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // every gamma entry written before any row reads it
        push_item(rnr_pkg::FUNC_GAMMA, 0, 32767);
        push_item(rnr_pkg::FUNC_GAMMA, 1, -32768);
        for (int i = 2; i < ROW_MAX - 1; i++) push_item(rnr_pkg::FUNC_GAMMA, i, rand_word());
        push_item(rnr_pkg::FUNC_GAMMA, 63, 256);
        drain();

        write_reg(rnr_pkg::REG_ROW_LENGTH, 4);
        write_reg(rnr_pkg::REG_EPSILON, 1);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 32767);
        push_item(rnr_pkg::FUNC_SAMPLE, 63, -32768);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 0);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 1);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 256);
        push_item(rnr_pkg::FUNC_GAMMA, 2, 512);          // load mid-row
        push_item(rnr_pkg::FUNC_SAMPLE, 0, -1);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, -256);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 100);
        drain();
        write_reg(rnr_pkg::REG_ROW_LENGTH, 0);            // zero length acts as one
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 32767);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, -32768);
        drain();
        write_reg(rnr_pkg::REG_EPSILON, 0);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 0);            // zero mean square, zero epsilon
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 1);
        drain();
        write_reg(rnr_pkg::REG_ROW_LENGTH, 8);
        write_reg(rnr_pkg::REG_EPSILON, 65535);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 1000);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, -2000);
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 30000);
        drain();
        write_reg(rnr_pkg::REG_ROW_LENGTH, 2);            // lowered mid-row
        push_item(rnr_pkg::FUNC_SAMPLE, 0, 5);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct  = idle_modes[ph][0];
            recv_stall_pct = idle_modes[ph][1];
            case ($urandom_range(7))
                0: n = 64;
                1: n = 127;
                2: n = 0;
                default: n = $urandom_range(1, 12);
            endcase
            write_reg(rnr_pkg::REG_ROW_LENGTH, n);
            case ($urandom_range(3))
                0: n = 0;
                1: n = 65535;
                default: n = $urandom_range(0, 65535);
            endcase
            write_reg(rnr_pkg::REG_EPSILON, n);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(9) < 2)
                    push_item(rnr_pkg::FUNC_GAMMA, $urandom_range(0, 63), rand_word());
                else
                    push_item(rnr_pkg::FUNC_SAMPLE, $urandom_range(0, 63), rand_word());
            end
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
